/* hdl/mtet_pkg.sv */
// Shared types and codes for the multi-timer expiry table.
`timescale 1ns / 1ps
`default_nettype none
package mtet_pkg;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [1:0] KIND_ADD_OK   = 2'd0;
	localparam logic [1:0] KIND_ADD_FULL = 2'd1;
	localparam logic [1:0] KIND_FIRED    = 2'd2;

	localparam int NOW_W    = 48;
	localparam int PERIOD_W = 32;
	localparam int EXPIRY_W = 49;
	localparam int TAG_W    = 32;
	localparam int LIVE_W   = 5;

	typedef struct packed {
		logic                periodic;
		logic [PERIOD_W-1:0] period;
		logic [EXPIRY_W-1:0] expiry;
		logic [TAG_W-1:0]    tag;
	} entry_t;

	typedef struct packed {
		logic shift_up;
		logic shift_down;
		logic insert;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADD,
		ST_DRAIN,
		ST_FLUSH
	} state_t;

endpackage
`default_nettype wire

/* hdl/mtet_cell.sv */
// One timer slot of the chain: holds, takes from either neighbor, or takes the head entry.
`timescale 1ns / 1ps
`default_nettype none
module mtet_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 5
) (
	input  wire                      clk,
	input  wire mtet_pkg::cell_ctl_t ctl,
	input  wire [CNT_W-1:0]          ins_pos,
	input  wire mtet_pkg::entry_t    prev_entry,
	input  wire mtet_pkg::entry_t    next_entry,
	input  wire mtet_pkg::entry_t    head_entry,
	output mtet_pkg::entry_t         entry
);

	mtet_pkg::entry_t entry_q;

	always_ff @(posedge clk) begin
		if (ctl.shift_up) begin
			entry_q <= prev_entry;
		end else if (ctl.shift_down) begin
			if (ctl.insert && (ins_pos == CNT_W'(IDX))) begin
				entry_q <= head_entry;
			end else begin
				entry_q <= next_entry;
			end
		end
	end

	assign entry = entry_q;

endmodule
`default_nettype wire

/* hdl/multi_timer_expiry_table_core.sv */
// Top level of the multi-timer expiry table: slot chain plus sequencing control.
//
// Input channel s_*: one transfer is an add (tuser 0) or a tick (tuser 1).
// Output channel m_*: status and fired-timer results, tlast on the final
// result caused by an input transfer.
// Timers sit in a chain of slots, newest in slot 0.
// An add is accepted; once the output register is free, the chain shifts by
// one slot (not when full) and the status result goes into the output register.
// A tick walks the chain: each cycle that no stall holds it, the head slot is
// checked against now, the chain shifts toward the head, and a kept timer
// (periodic ones rearmed) is written back behind the unchecked ones; while the
// output is not stalled, one fired result per cycle.
// Fired results pass through a one-entry holding register so tlast can be set
// once the walk ends.
// A new input is taken only when the previous one is fully done.
// When the receiver holds tready low, the walk stops at the next due timer
// and the output register keeps its transfer.
// Reset empties the table; slot contents need no clearing.
`timescale 1ns / 1ps
`default_nettype none
module multi_timer_expiry_table_core #(
	parameter int TIMERS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire [119:0] s_tdata,  // now_ms[47:0], period_ms[79:48], periodic[80], tag[112:81]
	input  wire         s_tuser,  // op
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,  // fired_tag[31:0], live_timers[36:32]
	output logic [1:0]  m_tuser,  // kind
	output logic        m_tlast
);

	localparam int CW = $clog2(TIMERS + 1);

	mtet_pkg::state_t state_q, state_d;

	logic [mtet_pkg::NOW_W-1:0]    now_q;
	logic [mtet_pkg::PERIOD_W-1:0] period_q;
	logic                          periodic_q;
	logic [mtet_pkg::TAG_W-1:0]    tag_q;

	logic [CW-1:0] count_q;
	logic [CW-1:0] rem_q;
	logic [CW-1:0] live_q;

	logic                       pend_valid_q;
	logic [mtet_pkg::TAG_W-1:0] pend_tag_q;
	logic [CW-1:0]              pend_live_q;

	logic        out_valid_q;
	logic [31:0] out_tag_q;
	logic [4:0]  out_live_q;
	logic [1:0]  out_kind_q;
	logic        out_last_q;

	mtet_pkg::entry_t cell_out [TIMERS];
	mtet_pkg::entry_t prev_w   [TIMERS];
	mtet_pkg::entry_t next_w   [TIMERS];
	mtet_pkg::entry_t new_entry;
	mtet_pkg::entry_t head;
	mtet_pkg::entry_t head_ins;
	mtet_pkg::cell_ctl_t ctl;

	logic                          out_free;
	logic                          accept;
	logic                          full;
	logic                          head_due;
	logic                          remove;
	logic [mtet_pkg::EXPIRY_W-1:0] now_ext;
	logic [mtet_pkg::EXPIRY_W-1:0] rearm;
	logic [CW-1:0]                 live_new;
	logic [CW-1:0]                 ins_pos;
	logic                          do_step;
	logic                          emit;
	logic [1:0]                    emit_kind;
	logic [31:0]                   emit_tag;
	logic                          emit_last;
	logic [CW-1:0]                 emit_live;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == mtet_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign full     = (count_q == CW'(TIMERS));

	assign now_ext  = {1'b0, now_q};
	assign head     = cell_out[0];
	assign head_due = (head.expiry <= now_ext);
	assign rearm    = now_ext + {{(mtet_pkg::EXPIRY_W - mtet_pkg::PERIOD_W){1'b0}}, head.period};
	assign remove   = head_due && !head.periodic;
	assign live_new = live_q - CW'(remove);
	assign ins_pos  = live_q - CW'(1);

	always_comb begin
		new_entry.periodic = periodic_q;
		new_entry.period   = period_q;
		new_entry.expiry   = now_ext
			+ {{(mtet_pkg::EXPIRY_W - mtet_pkg::PERIOD_W){1'b0}}, period_q};
		new_entry.tag      = tag_q;
		head_ins           = head;
		if (head_due) begin
			head_ins.expiry = rearm;
		end
	end

	// slot chain
	for (genvar i = 0; i < TIMERS; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign prev_w[i] = new_entry;
		end else begin : g_mid
			assign prev_w[i] = cell_out[i-1];
		end
		if (i == TIMERS - 1) begin : g_last
			assign next_w[i] = cell_out[i];
		end else begin : g_inner
			assign next_w[i] = cell_out[i+1];
		end
		mtet_cell #(
			.IDX   (i),
			.CNT_W (CW)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.ins_pos    (ins_pos),
			.prev_entry (prev_w[i]),
			.next_entry (next_w[i]),
			.head_entry (head_ins),
			.entry      (cell_out[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtet_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		ctl            = '0;
		do_step        = 1'b0;
		emit           = 1'b0;
		emit_kind      = mtet_pkg::KIND_FIRED;
		emit_tag       = pend_tag_q;
		emit_last      = 1'b0;
		emit_live      = pend_live_q;
		unique case (state_q)
			mtet_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = (s_tuser == mtet_pkg::OP_ADD) ? mtet_pkg::ST_ADD
						: mtet_pkg::ST_DRAIN;
				end
			end
			mtet_pkg::ST_ADD: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_tag  = tag_q;
					emit_last = 1'b1;
					if (full) begin
						emit_kind = mtet_pkg::KIND_ADD_FULL;
						emit_live = count_q;
					end else begin
						emit_kind    = mtet_pkg::KIND_ADD_OK;
						emit_live    = count_q + CW'(1);
						ctl.shift_up = 1'b1;
					end
					state_d = mtet_pkg::ST_IDLE;
				end
			end
			mtet_pkg::ST_DRAIN: begin
				if (rem_q == '0) begin
					state_d = mtet_pkg::ST_FLUSH;
				end else if (!(head_due && pend_valid_q && !out_free)) begin
					do_step        = 1'b1;
					ctl.shift_down = 1'b1;
					ctl.insert     = !remove;
					emit           = head_due && pend_valid_q;
				end
			end
			mtet_pkg::ST_FLUSH: begin
				if (!pend_valid_q) begin
					state_d = mtet_pkg::ST_IDLE;
				end else if (out_free) begin
					emit      = 1'b1;
					emit_last = 1'b1;
					state_d   = mtet_pkg::ST_IDLE;
				end
			end
			default: state_d = mtet_pkg::ST_IDLE;
		endcase
	end

	// input item capture
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q      <= s_tdata[47:0];
			period_q   <= s_tdata[79:48];
			periodic_q <= s_tdata[80];
			tag_q      <= s_tdata[112:81];
		end
	end

	// counters and pending fired result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			rem_q        <= '0;
			live_q       <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				rem_q  <= count_q;
				live_q <= count_q;
			end
			if (ctl.shift_up) begin
				count_q <= count_q + CW'(1);
			end
			if (do_step) begin
				rem_q  <= rem_q - CW'(1);
				live_q <= live_new;
				if (head_due) begin
					pend_valid_q <= 1'b1;
				end
			end
			if (state_q == mtet_pkg::ST_DRAIN && rem_q == '0) begin
				count_q <= live_q;
			end
			if (state_q == mtet_pkg::ST_FLUSH && emit) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_step && head_due) begin
			pend_tag_q  <= head.tag;
			pend_live_q <= live_new;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind_q <= emit_kind;
			out_tag_q  <= emit_tag;
			out_last_q <= emit_last;
			out_live_q <= 5'(emit_live);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_live_q, out_tag_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule
`default_nettype wire

/* verif/multi_timer_expiry_table_core_tb.sv */
// Self-checking testbench for the multi-timer expiry table core: predicted results vs. stream output.
`timescale 1ns / 1ps
module multi_timer_expiry_table_core_tb;
	import mtet_pkg::*;

	localparam int TIMERS      = 16;
	localparam int N_RANDOM    = 380;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 4000;
	localparam logic [NOW_W-1:0] NOW_MAX = '1;

	typedef struct packed {
		logic [1:0]        kind;
		logic [TAG_W-1:0]  tag;
		logic              last;
		logic [LIVE_W-1:0] live;
	} outcome_t;

	class expiry_table_sb;
		logic                slot_periodic[TIMERS];
		logic [PERIOD_W-1:0] slot_period[TIMERS];
		logic [EXPIRY_W-1:0] slot_due[TIMERS];
		logic [TAG_W-1:0]    slot_tag[TIMERS];
		int unsigned         held;
		outcome_t            pending_outcomes[$];
		int mismatches, adds, rejects, ticks, fired, peak_held;

		function new();
			held       = 0;
			mismatches = 0;
			adds       = 0;
			rejects    = 0;
			ticks      = 0;
			fired      = 0;
			peak_held  = 0;
		endfunction

		function void accept_command(logic op, logic [NOW_W-1:0] now,
				logic [PERIOD_W-1:0] period, logic periodic, logic [TAG_W-1:0] tag);
			int unsigned live, w;
			int n;
			logic keep;
			if (op == OP_ADD) begin
				adds++;
				if (held >= TIMERS) begin
					rejects++;
					pending_outcomes.push_back('{KIND_ADD_FULL, tag, 1'b1, LIVE_W'(held)});
					return;
				end
				for (int r = int'(held); r > 0; r--) begin
					slot_periodic[r] = slot_periodic[r-1];
					slot_period[r]   = slot_period[r-1];
					slot_due[r]      = slot_due[r-1];
					slot_tag[r]      = slot_tag[r-1];
				end
				slot_periodic[0] = periodic;
				slot_period[0]   = period;
				slot_due[0]      = {1'b0, now} + EXPIRY_W'(period);
				slot_tag[0]      = tag;
				held++;
				if (held > peak_held)
					peak_held = held;
				pending_outcomes.push_back('{KIND_ADD_OK, tag, 1'b1, LIVE_W'(held)});
				return;
			end
			// tick: newest first, kept timers compact toward the head
			ticks++;
			live = held;
			w    = 0;
			n    = 0;
			for (int r = 0; r < int'(held); r++) begin
				keep = 1'b1;
				if (slot_due[r] <= {1'b0, now}) begin
					if (slot_periodic[r]) begin
						slot_due[r] = {1'b0, now} + EXPIRY_W'(slot_period[r]);
					end else begin
						keep = 1'b0;
						live--;
					end
					pending_outcomes.push_back('{KIND_FIRED, slot_tag[r], 1'b0, LIVE_W'(live)});
					fired++;
					n++;
				end
				if (keep) begin
					slot_periodic[w] = slot_periodic[r];
					slot_period[w]   = slot_period[r];
					slot_due[w]      = slot_due[r];
					slot_tag[w]      = slot_tag[r];
					w++;
				end
			end
			held = w;
			if (n > 0)
				pending_outcomes[pending_outcomes.size()-1].last = 1'b1;
		endfunction

		task report_mismatch(string what);
			if (mismatches < 50)
				$display("[%0t] MISMATCH: %s", $realtime, what);
			mismatches++;
		endtask

		task check_outcome(logic [1:0] kind, logic [TAG_W-1:0] tag, logic last,
				logic [LIVE_W-1:0] live);
			outcome_t want;
			if (pending_outcomes.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind %0d tag %h", kind, tag));
				return;
			end
			want = pending_outcomes.pop_front();
			if (kind !== want.kind)
				report_mismatch($sformatf("kind %0d, expected %0d (tag %h)", kind, want.kind,
					want.tag));
			if (tag !== want.tag)
				report_mismatch($sformatf("tag %h, expected %h", tag, want.tag));
			if (last !== want.last)
				report_mismatch($sformatf("tlast %b, expected %b (tag %h)", last, want.last,
					want.tag));
			if (live !== want.live)
				report_mismatch($sformatf("live_timers %0d, expected %0d (tag %h)", live,
					want.live, want.tag));
		endtask
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [119:0] s_tdata;  // now_ms[47:0], period_ms[79:48], periodic[80], tag[112:81]
	logic         s_tuser;  // op
	logic         m_tvalid;
	logic         m_tready;
	logic [39:0]  m_tdata;  // fired_tag[31:0], live_timers[36:32]
	logic [1:0]   m_tuser;  // kind
	logic         m_tlast;

	expiry_table_sb   sb = new();
	int               send_idle_pct = 0;
	int               recv_stall_pct = 0;
	bit               hold_req = 1'b0;
	int               quiet_cycles = 0;
	logic [NOW_W-1:0] clock_ms;

	multi_timer_expiry_table_core #(
		.TIMERS(TIMERS)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_item(input logic op, input logic [NOW_W-1:0] now,
			input logic [PERIOD_W-1:0] period, input logic periodic,
			input logic [TAG_W-1:0] tag);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {7'd0, tag, periodic, period, now};
		forever begin
			@(posedge clk);
			if (s_tready)
				break;
		end
		sb.accept_command(op, now, period, periodic, tag);
	endtask

	task automatic add_timer(input logic [NOW_W-1:0] now, input logic [PERIOD_W-1:0] period,
			input logic periodic, input logic [TAG_W-1:0] tag);
		send_item(OP_ADD, now, period, periodic, tag);
	endtask

	// unused fields of a tick carry random content
	task automatic tick(input logic [NOW_W-1:0] now);
		send_item(OP_TICK, now, $urandom, 1'($urandom_range(1)), $urandom);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	// bursts of adds at the current time, then ticks that advance it
	task automatic random_traffic(input int count);
		int sent, burst;
		logic [PERIOD_W-1:0] period;
		logic periodic;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 6);
			if ($urandom_range(7) == 0)
				burst = $urandom_range(8, 18);
			for (int i = 0; i < burst && sent < count; i++) begin
				periodic = ($urandom_range(39) == 0);
				period   = periodic ? $urandom_range(0, 30) : $urandom_range(0, 40);
				if (!periodic && $urandom_range(63) == 0)
					period = $urandom;
				add_timer(clock_ms, period, periodic, $urandom);
				sent++;
			end
			for (int i = $urandom_range(1, 3); i > 0 && sent < count; i--) begin
				clock_ms = clock_ms + $urandom_range(0, 30);
				if ($urandom_range(15) == 0)
					tick(clock_ms - $urandom_range(0, 10));  // stale time
				else
					tick(clock_ms);
				sent++;
			end
		end
	endtask

	initial begin
		int unsigned held_for;
		held_for = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				held_for++;
				if (held_for == HOLD_CYCLES) begin
					hold_req = 1'b0;
					held_for = 0;
				end
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_outcome(m_tuser, m_tdata[TAG_W-1:0], m_tlast,
				m_tdata[TAG_W+LIVE_W-1:TAG_W]);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles, %0d results outstanding",
				STALL_LIMIT, sb.pending_outcomes.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tuser  = OP_ADD;
		s_tdata  = '0;
		clock_ms = 48'd100;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		tick(48'd0);
		add_timer(48'd0, '1, 1'b0, 32'd0);
		add_timer(NOW_MAX, 32'd0, 1'b0, '1);
		tick(48'd0);
		for (int i = 0; i < TIMERS - 2; i++)
			add_timer(48'd0, $urandom_range(0, 3), 1'b0, $urandom);
		add_timer(48'd1, 32'd5, 1'b0, $urandom);  // table full
		tick(48'd2);
		tick(NOW_MAX);
		add_timer(48'd0, 32'd0, 1'b1, $urandom);  // zero period: due on every tick whose time has not gone back
		add_timer(48'd0, 32'd7, 1'b1, $urandom);
		tick(48'd0);
		wait_drained();

		// long receiver hold-off while the sender keeps offering
		hold_req = 1'b1;
		random_traffic(N_RANDOM / 4);
		wait_drained();
		send_idle_pct  = 48;
		recv_stall_pct = 0;
		random_traffic(N_RANDOM / 4);
		wait_drained();
		send_idle_pct  = 0;
		recv_stall_pct = 48;
		random_traffic(N_RANDOM / 4);
		wait_drained();
		send_idle_pct  = 8;
		recv_stall_pct = 8;
		random_traffic(N_RANDOM / 4);
		tick(NOW_MAX);
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait_drained();
		repeat (40) @(posedge clk);

		$display("Covered %0d adds (%0d rejected on a full table, peak %0d held), %0d ticks,",
			sb.adds, sb.rejects, sb.peak_held, sb.ticks);
		$display("%0d fired timers, under no idling, sender gaps, receiver stalls and both.",
			sb.fired);
		if (sb.mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

/* sim.f */
hdl/mtet_pkg.sv
hdl/mtet_cell.sv
hdl/multi_timer_expiry_table_core.sv
verif/multi_timer_expiry_table_core_tb.sv
